@@ src/pulse_channel_sweep_envelope_top_defines.svh @@
// Assertion macros shared by the pulse channel checker.
`ifndef PULSE_CHANNEL_SWEEP_ENVELOPE_TOP_DEFINES_SVH
`define PULSE_CHANNEL_SWEEP_ENVELOPE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/pcse_pkg.sv @@
// Shared types, constants and helpers of the pulse channel.
`default_nettype none

package pcse_pkg;

  // Command codes on the input channel
  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_TICK   = 3'd2;
  localparam logic [2:0] CMD_LENGTH = 3'd3;
  localparam logic [2:0] CMD_ENV    = 3'd4;
  localparam logic [2:0] CMD_SWEEP  = 3'd5;

  // Register addresses
  localparam logic [15:0] NR10_ADDR = 16'hFF10;
  localparam logic [15:0] NR11_ADDR = 16'hFF11;
  localparam logic [15:0] NR12_ADDR = 16'hFF12;
  localparam logic [15:0] NR13_ADDR = 16'hFF13;
  localparam logic [15:0] NR14_ADDR = 16'hFF14;

  localparam logic [11:0] PERIOD_SPAN  = 12'd2048;
  localparam logic [6:0]  LENGTH_FULL  = 7'd64;
  localparam logic [3:0]  PACE_DEFAULT = 4'd8;
  localparam logic [3:0]  VOLUME_MAX   = 4'd15;

  localparam int QUEUE_DEPTH = 2;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_TICK,
    OP_LENGTH,
    OP_ENV,
    OP_SWEEP,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    REG_NR10,
    REG_NR11,
    REG_NR12,
    REG_NR13,
    REG_NR14,
    REG_NONE
  } reg_sel_t;

  typedef struct packed {
    op_t        op;
    reg_sel_t   reg_sel;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Frequency timer reload: (2048 - period) * 4
  function automatic logic [13:0] timer_reload(input logic [10:0] period);
    logic [11:0] span;
    span = PERIOD_SPAN - {1'b0, period};
    return {span, 2'b00};
  endfunction

endpackage

`default_nettype wire

@@ src/pcse_front.sv @@
// Front end: accept input items and decode them into queue commands.
`default_nettype none

module pcse_front (
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [pcse_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic [pcse_pkg::IN_USER_W-1:0]     in_tuser,
  input  wire pcse_pkg::q_status_t                q_status,
  output logic                                    push,
  output pcse_pkg::cmd_t                          push_cmd
);

  logic [15:0] addr;

  assign addr      = in_tdata[15:0];
  assign in_tready = !q_status.full;
  assign push      = in_tvalid && !q_status.full;

  // Classify command and register select
  always_comb begin
    push_cmd.data = in_tdata[23:16];
    case (in_tuser)
      pcse_pkg::CMD_WRITE:  push_cmd.op = pcse_pkg::OP_WRITE;
      pcse_pkg::CMD_READ:   push_cmd.op = pcse_pkg::OP_READ;
      pcse_pkg::CMD_TICK:   push_cmd.op = pcse_pkg::OP_TICK;
      pcse_pkg::CMD_LENGTH: push_cmd.op = pcse_pkg::OP_LENGTH;
      pcse_pkg::CMD_ENV:    push_cmd.op = pcse_pkg::OP_ENV;
      pcse_pkg::CMD_SWEEP:  push_cmd.op = pcse_pkg::OP_SWEEP;
      default:              push_cmd.op = pcse_pkg::OP_NONE;
    endcase
    case (addr)
      pcse_pkg::NR10_ADDR: push_cmd.reg_sel = pcse_pkg::REG_NR10;
      pcse_pkg::NR11_ADDR: push_cmd.reg_sel = pcse_pkg::REG_NR11;
      pcse_pkg::NR12_ADDR: push_cmd.reg_sel = pcse_pkg::REG_NR12;
      pcse_pkg::NR13_ADDR: push_cmd.reg_sel = pcse_pkg::REG_NR13;
      pcse_pkg::NR14_ADDR: push_cmd.reg_sel = pcse_pkg::REG_NR14;
      default:             push_cmd.reg_sel = pcse_pkg::REG_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/pcse_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none

module pcse_queue #(
  parameter int DEPTH = pcse_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire pcse_pkg::cmd_t       push_cmd,
  input  wire logic                 pop,
  output pcse_pkg::cmd_t            pop_cmd,
  output pcse_pkg::q_status_t       status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pcse_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full      = (count_r == FULL_CNT);
  assign status.not_empty = (count_r != '0);
  assign pop_cmd          = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold command payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ src/pcse_back.sv @@
// Back end: channel state, command execution and the result register.
`default_nettype none

module pcse_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pcse_pkg::q_status_t                 q_status,
  input  wire pcse_pkg::cmd_t                      cmd,
  output logic                                     pop,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [pcse_pkg::OUT_DATA_W-1:0]          out_tdata
);

  // Channel registers
  logic [3:0]  sweep_pace_r,    sweep_pace_nxt;
  logic        sweep_negate_r,  sweep_negate_nxt;
  logic [2:0]  sweep_shift_r,   sweep_shift_nxt;
  logic [1:0]  duty_select_r,   duty_select_nxt;
  logic [6:0]  length_left_r,   length_left_nxt;
  logic [3:0]  start_volume_r,  start_volume_nxt;
  logic        env_increase_r,  env_increase_nxt;
  logic [2:0]  env_pace_r,      env_pace_nxt;
  logic [10:0] period_r,        period_nxt;
  logic        length_enable_r, length_enable_nxt;
  logic        chan_enabled_r,  chan_enabled_nxt;
  logic [3:0]  cur_volume_r,    cur_volume_nxt;
  logic        env_running_r,   env_running_nxt;
  logic [3:0]  env_counter_r,   env_counter_nxt;
  logic [3:0]  sweep_counter_r, sweep_counter_nxt;
  logic [10:0] shadow_r,        shadow_nxt;
  logic        sweep_active_r,  sweep_active_nxt;
  logic [13:0] freq_timer_r,    freq_timer_nxt;
  logic [2:0]  seq_pos_r,       seq_pos_nxt;
  logic [3:0]  level_r,         level_nxt;

  // Result register
  logic                              out_valid_r, out_valid_nxt;
  logic [pcse_pkg::OUT_DATA_W-1:0]   out_data_r,  out_data_nxt;

  logic        advance;
  logic [7:0]  rd_byte;
  logic [10:0] wr_period;
  logic [11:0] sweep_delta;
  logic [11:0] sweep_next;
  logic [3:0]  vol_env;
  logic [3:0]  level_shown;

  assign advance    = q_status.not_empty && (!out_valid_r || out_tready);
  assign pop        = advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sweep step and period with the NR14 high bits applied
  assign sweep_delta = {1'b0, shadow_r} >> sweep_shift_r;
  assign sweep_next  = sweep_negate_r ? ({1'b0, shadow_r} - sweep_delta)
                                      : ({1'b0, shadow_r} + sweep_delta);
  assign wr_period   = {cmd.data[2:0], period_r[7:0]};

  // Execute one command
  always_comb begin
    sweep_pace_nxt    = sweep_pace_r;
    sweep_negate_nxt  = sweep_negate_r;
    sweep_shift_nxt   = sweep_shift_r;
    duty_select_nxt   = duty_select_r;
    length_left_nxt   = length_left_r;
    start_volume_nxt  = start_volume_r;
    env_increase_nxt  = env_increase_r;
    env_pace_nxt      = env_pace_r;
    period_nxt        = period_r;
    length_enable_nxt = length_enable_r;
    chan_enabled_nxt  = chan_enabled_r;
    cur_volume_nxt    = cur_volume_r;
    env_running_nxt   = env_running_r;
    env_counter_nxt   = env_counter_r;
    sweep_counter_nxt = sweep_counter_r;
    shadow_nxt        = shadow_r;
    sweep_active_nxt  = sweep_active_r;
    freq_timer_nxt    = freq_timer_r;
    seq_pos_nxt       = seq_pos_r;
    level_nxt         = level_r;
    rd_byte           = 8'd0;
    vol_env           = cur_volume_r;

    case (cmd.op)
      pcse_pkg::OP_WRITE: begin
        case (cmd.reg_sel)
          pcse_pkg::REG_NR10: begin
            sweep_pace_nxt   = cmd.data[7:4];
            sweep_negate_nxt = cmd.data[3];
            sweep_shift_nxt  = cmd.data[2:0];
          end
          pcse_pkg::REG_NR11: begin
            duty_select_nxt = cmd.data[7:6];
            length_left_nxt = pcse_pkg::LENGTH_FULL - {1'b0, cmd.data[5:0]};
          end
          pcse_pkg::REG_NR12: begin
            start_volume_nxt = cmd.data[7:4];
            env_increase_nxt = cmd.data[3];
            env_pace_nxt     = cmd.data[2:0];
          end
          pcse_pkg::REG_NR13: begin
            period_nxt = {period_r[10:8], cmd.data};
          end
          pcse_pkg::REG_NR14: begin
            period_nxt        = wr_period;
            length_enable_nxt = cmd.data[6];
            // Trigger: restart the channel from the new period
            if (cmd.data[7]) begin
              chan_enabled_nxt = 1'b1;
              if (length_left_r == '0) begin
                length_left_nxt = pcse_pkg::LENGTH_FULL;
              end
              freq_timer_nxt    = pcse_pkg::timer_reload(wr_period);
              env_running_nxt   = 1'b1;
              env_counter_nxt   = {1'b0, env_pace_r};
              cur_volume_nxt    = start_volume_r;
              shadow_nxt        = wr_period;
              sweep_counter_nxt = (sweep_pace_r != '0) ? sweep_pace_r
                                                       : pcse_pkg::PACE_DEFAULT;
              sweep_active_nxt  = (sweep_pace_r != '0) || (sweep_shift_r != '0);
            end
          end
          default: begin
          end
        endcase
      end

      pcse_pkg::OP_READ: begin
        case (cmd.reg_sel)
          pcse_pkg::REG_NR10: rd_byte = {sweep_pace_r, sweep_negate_r, sweep_shift_r};
          pcse_pkg::REG_NR11: rd_byte = {duty_select_r, 6'd0};
          pcse_pkg::REG_NR12: rd_byte = {start_volume_r, env_increase_r, env_pace_r};
          pcse_pkg::REG_NR14: rd_byte = {1'b0, length_enable_r, 6'd0};
          default:            rd_byte = 8'd0;
        endcase
      end

      pcse_pkg::OP_TICK: begin
        if (freq_timer_r <= 14'd1) begin
          freq_timer_nxt = pcse_pkg::timer_reload(period_r);
          seq_pos_nxt    = seq_pos_r + 1'b1;
        end else begin
          freq_timer_nxt = freq_timer_r - 1'b1;
        end
        level_nxt = chan_enabled_r ? cur_volume_r : 4'd0;
      end

      pcse_pkg::OP_LENGTH: begin
        if ((length_left_r != '0) && length_enable_r) begin
          length_left_nxt = length_left_r - 1'b1;
          if (length_left_r == 7'd1) begin
            chan_enabled_nxt = 1'b0;
          end
        end
      end

      pcse_pkg::OP_ENV: begin
        if (env_counter_r > 4'd1) begin
          env_counter_nxt = env_counter_r - 1'b1;
        end else begin
          env_counter_nxt = (env_pace_r != '0) ? {1'b0, env_pace_r}
                                               : pcse_pkg::PACE_DEFAULT;
          if (env_running_r && (env_pace_r != '0)) begin
            if (env_increase_r && (cur_volume_r != pcse_pkg::VOLUME_MAX)) begin
              vol_env = cur_volume_r + 1'b1;
            end else if (!env_increase_r && (cur_volume_r != '0)) begin
              vol_env = cur_volume_r - 1'b1;
            end
          end
          cur_volume_nxt = vol_env;
          if ((vol_env == '0) || (vol_env == pcse_pkg::VOLUME_MAX)) begin
            env_running_nxt = 1'b0;
          end
        end
      end

      pcse_pkg::OP_SWEEP: begin
        if (sweep_counter_r > 4'd1) begin
          sweep_counter_nxt = sweep_counter_r - 1'b1;
        end else begin
          sweep_counter_nxt = (sweep_pace_r != '0) ? sweep_pace_r
                                                   : pcse_pkg::PACE_DEFAULT;
          // Apply the new period unless it overflows or the shift is zero
          if (sweep_active_r && (sweep_pace_r != '0) && !sweep_next[11] &&
              (sweep_shift_r != '0)) begin
            shadow_nxt = sweep_next[10:0];
            period_nxt = sweep_next[10:0];
          end
        end
      end

      default: begin
      end
    endcase
  end

  // Pack the result: read_data, output_level, length_running, channel_on, duty_step
  assign level_shown = chan_enabled_nxt ? level_nxt : 4'd0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'd0, seq_pos_nxt, chan_enabled_nxt, (length_left_nxt != '0),
                       level_shown, rd_byte};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_pace_r    <= '0;
      sweep_negate_r  <= 1'b0;
      sweep_shift_r   <= '0;
      duty_select_r   <= '0;
      length_left_r   <= '0;
      start_volume_r  <= '0;
      env_increase_r  <= 1'b0;
      env_pace_r      <= '0;
      period_r        <= '0;
      length_enable_r <= 1'b0;
      chan_enabled_r  <= 1'b0;
      cur_volume_r    <= '0;
      env_running_r   <= 1'b1;
      env_counter_r   <= '0;
      sweep_counter_r <= '0;
      shadow_r        <= '0;
      sweep_active_r  <= 1'b0;
      freq_timer_r    <= '0;
      seq_pos_r       <= '0;
      level_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        sweep_pace_r    <= sweep_pace_nxt;
        sweep_negate_r  <= sweep_negate_nxt;
        sweep_shift_r   <= sweep_shift_nxt;
        duty_select_r   <= duty_select_nxt;
        length_left_r   <= length_left_nxt;
        start_volume_r  <= start_volume_nxt;
        env_increase_r  <= env_increase_nxt;
        env_pace_r      <= env_pace_nxt;
        period_r        <= period_nxt;
        length_enable_r <= length_enable_nxt;
        chan_enabled_r  <= chan_enabled_nxt;
        cur_volume_r    <= cur_volume_nxt;
        env_running_r   <= env_running_nxt;
        env_counter_r   <= env_counter_nxt;
        sweep_counter_r <= sweep_counter_nxt;
        shadow_r        <= shadow_nxt;
        sweep_active_r  <= sweep_active_nxt;
        freq_timer_r    <= freq_timer_nxt;
        seq_pos_r       <= seq_pos_nxt;
        level_r         <= level_nxt;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

@@ src/pulse_channel_sweep_envelope_top.sv @@
// Top level of the pulse channel with sweep, envelope and length counter.
// Path: an item passes the queue, then the back-end result register, before out_tvalid shows it.
// Throughput: one item per cycle while out_tready stays high; each pop executes one command.
// Stalls: with out_tready low the queue (QUEUE_DEPTH entries) and the result register
// take QUEUE_DEPTH + 1 items, then in_tready drops.
// Reset (rst_n low, synchronous) clears the channel state, empties the queue and the result.
`default_nettype none

module pulse_channel_sweep_envelope_top #(
  parameter int QUEUE_DEPTH = pcse_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // reg_address [15:0], write_data [23:16]
  input  wire logic [pcse_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd [2:0]
  input  wire logic [pcse_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // read_data [7:0], output_level [11:8], length_running [12], channel_on [13],
  // duty_step [16:14], zero [23:17]
  output logic [pcse_pkg::OUT_DATA_W-1:0]         out_tdata
);

  pcse_pkg::q_status_t q_status;
  pcse_pkg::cmd_t      push_cmd;
  pcse_pkg::cmd_t      pop_cmd;
  logic                push;
  logic                pop;

  pcse_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pcse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  pcse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .cmd        (pop_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

@@ src/pcse_checker.sv @@
// Port-level checker for the pulse channel and its bind to the top level.
`default_nettype none

`include "pulse_channel_sweep_envelope_top_defines.svh"

module pcse_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [pcse_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // Stalled result holds
  `PCSE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Disabled channel shows silence
  `PCSE_ASSERT_NOW(a_off_silent, out_tvalid && !out_tdata[13], out_tdata[11:8] == 4'd0, "level nonzero while channel off")

  // Padding bits stay clear
  `PCSE_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[23:17] == 7'd0, "result padding not zero")

  // With no result pending now or just before, the queue cannot be full
  `PCSE_ASSERT_NOW(a_ready_when_drained, !out_tvalid && $past(!out_tvalid), in_tready, "input stalled while back end idle")

endmodule

bind pulse_channel_sweep_envelope_top pcse_checker u_pcse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the pulse channel with sweep, envelope and length counter.
module tb;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 100;

  // Command codes the block does not define
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  // Addresses outside the register map
  localparam logic [15:0] ADDR_UNMAPPED_LO = 16'h0000;
  localparam logic [15:0] ADDR_UNMAPPED_HI = 16'hFF15;
  localparam logic [15:0] ADDR_TOP         = 16'hFFFF;

  localparam logic [10:0] PERIOD_MAX = 11'd2047;

  // Result fields, lowest bit last in the list
  typedef struct packed {
    logic [6:0] pad;
    logic [2:0] duty_step;
    logic       channel_on;
    logic       length_running;
    logic [3:0] output_level;
    logic [7:0] read_data;
  } chan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;

  // Channel state as predicted
  logic [3:0]  sw_pace, vol_init, volume, env_cnt, sw_cnt, level;
  logic        sw_neg, env_up, len_en, enabled, env_live, sw_live;
  logic [2:0]  sw_shift, env_pace, step;
  logic [1:0]  duty_sel;
  logic [6:0]  len_left;
  logic [10:0] period, shadow;
  logic [13:0] ftimer;

  chan_result_t pending_results[$];
  int           n_fail = 0;
  int           burst_left = 0;
  bit           gaps_on = 1'b1;
  int           hold_asked = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           rx_mode = 0;
  int           mode_left = 0;
  int           idle_cycles = 0;

  pulse_channel_sweep_envelope_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [13:0] period_reload(logic [10:0] p);
    logic [11:0] span;
    span = pcse_pkg::PERIOD_SPAN - {1'b0, p};
    return {span, 2'b00};
  endfunction

  // Advance the predicted channel by one command and return its result
  function automatic chan_result_t step_channel(logic [2:0] op, logic [15:0] addr,
                                                logic [7:0] v);
    chan_result_t r;
    int unsigned  sh, delta, next_period;
    r = '0;
    case (op)
      pcse_pkg::CMD_WRITE: begin
        case (addr)
          pcse_pkg::NR10_ADDR: begin
            sw_pace = v[7:4];
            sw_neg = v[3];
            sw_shift = v[2:0];
          end
          pcse_pkg::NR11_ADDR: begin
            duty_sel = v[7:6];
            len_left = pcse_pkg::LENGTH_FULL - {1'b0, v[5:0]};
          end
          pcse_pkg::NR12_ADDR: begin
            vol_init = v[7:4];
            env_up = v[3];
            env_pace = v[2:0];
          end
          pcse_pkg::NR13_ADDR: period[7:0] = v;
          pcse_pkg::NR14_ADDR: begin
            period[10:8] = v[2:0];
            // Trigger: enable the channel, restart timer, envelope and sweep
            if (v[7]) begin
              enabled = 1'b1;
              if (len_left == 0) len_left = pcse_pkg::LENGTH_FULL;
              ftimer = period_reload(period);
              env_live = 1'b1;
              env_cnt = {1'b0, env_pace};
              volume = vol_init;
              shadow = period;
              sw_cnt = (sw_pace != 0) ? sw_pace : pcse_pkg::PACE_DEFAULT;
              sw_live = (sw_pace != 0) || (sw_shift != 0);
            end
            len_en = v[6];
          end
          default: ;
        endcase
      end
      pcse_pkg::CMD_READ: begin
        case (addr)
          pcse_pkg::NR10_ADDR: r.read_data = {sw_pace, sw_neg, sw_shift};
          pcse_pkg::NR11_ADDR: r.read_data = {duty_sel, 6'b0};
          pcse_pkg::NR12_ADDR: r.read_data = {vol_init, env_up, env_pace};
          pcse_pkg::NR14_ADDR: r.read_data = {1'b0, len_en, 6'b0};
          default: ;
        endcase
      end
      pcse_pkg::CMD_TICK: begin
        if (ftimer < 2) begin
          ftimer = period_reload(period);
          step = step + 3'd1;
        end else begin
          ftimer = ftimer - 14'd1;
        end
        level = enabled ? volume : 4'd0;
      end
      pcse_pkg::CMD_LENGTH: begin
        if (len_left != 0 && len_en) begin
          len_left = len_left - 7'd1;
          if (len_left == 0) enabled = 1'b0;
        end
      end
      pcse_pkg::CMD_ENV: begin
        if (env_cnt > 1) begin
          env_cnt = env_cnt - 4'd1;
        end else begin
          env_cnt = (env_pace != 0) ? {1'b0, env_pace} : pcse_pkg::PACE_DEFAULT;
          if (env_live && env_pace != 0) begin
            if (env_up && volume < pcse_pkg::VOLUME_MAX) volume = volume + 4'd1;
            else if (!env_up && volume > 0) volume = volume - 4'd1;
          end
          if (volume == 0 || volume == pcse_pkg::VOLUME_MAX) env_live = 1'b0;
        end
      end
      pcse_pkg::CMD_SWEEP: begin
        if (sw_cnt > 1) begin
          sw_cnt = sw_cnt - 4'd1;
        end else begin
          sw_cnt = (sw_pace != 0) ? sw_pace : pcse_pkg::PACE_DEFAULT;
          if (sw_live && sw_pace != 0) begin
            sh = shadow;
            delta = sh >> sw_shift;
            next_period = sw_neg ? sh - delta : sh + delta;
            // Overflow or zero shift keeps the old period
            if (next_period <= PERIOD_MAX && sw_shift != 0) begin
              shadow = 11'(next_period);
              period = 11'(next_period);
            end
          end
        end
      end
      default: ;
    endcase
    r.output_level = enabled ? level : 4'd0;
    r.length_running = (len_left != 0);
    r.channel_on = enabled;
    r.duty_step = step;
    return r;
  endfunction

  function automatic logic [15:0] pick_reg_addr();
    return pcse_pkg::NR10_ADDR + 16'($urandom_range(0, 4));
  endfunction

  // Offer one item in bursts (random gaps if gaps_on), record its result on acceptance
  task automatic send_item(logic [2:0] op, logic [15:0] addr, logic [7:0] v);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {v, addr};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(step_channel(op, addr, v));
  endtask

  // Reset-state reads, unknown commands and addresses, register extremes
  task automatic test_register_access_and_corners();
    send_item(pcse_pkg::CMD_READ, pcse_pkg::NR10_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_READ, ADDR_UNMAPPED_LO, 8'hFF);
    send_item(CMD_UNUSED_6, ADDR_TOP, 8'hFF);
    send_item(CMD_UNUSED_7, ADDR_UNMAPPED_LO, 8'h00);
    // Timer, envelope and sweep counters found at zero
    send_item(pcse_pkg::CMD_TICK, pcse_pkg::NR10_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_ENV, pcse_pkg::NR10_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_SWEEP, pcse_pkg::NR10_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_WRITE, ADDR_UNMAPPED_HI, 8'hFF);
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR10_ADDR, 8'hFF);
    send_item(pcse_pkg::CMD_READ, pcse_pkg::NR10_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR11_ADDR, 8'hFF);
    send_item(pcse_pkg::CMD_READ, pcse_pkg::NR11_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR12_ADDR, 8'hF8);
    send_item(pcse_pkg::CMD_READ, pcse_pkg::NR12_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR13_ADDR, 8'hFF);
    send_item(pcse_pkg::CMD_READ, pcse_pkg::NR13_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR14_ADDR, 8'hC7);
    send_item(pcse_pkg::CMD_READ, pcse_pkg::NR14_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_TICK, pcse_pkg::NR10_ADDR, 8'h00);
    // Volume at the top stops the envelope; length runs out and disables
    send_item(pcse_pkg::CMD_ENV, pcse_pkg::NR10_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_LENGTH, pcse_pkg::NR10_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_TICK, pcse_pkg::NR10_ADDR, 8'h00);
    // Trigger with zero length, then a sweep that overflows
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR10_ADDR, 8'h11);
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR14_ADDR, 8'h87);
    send_item(pcse_pkg::CMD_SWEEP, pcse_pkg::NR10_ADDR, 8'h00);
    // Zero shift leaves the period alone
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR10_ADDR, 8'h18);
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR14_ADDR, 8'h80);
    send_item(pcse_pkg::CMD_SWEEP, pcse_pkg::NR10_ADDR, 8'h00);
    send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR11_ADDR, 8'h00);
  endtask

  // Program the channel, trigger it, then run a random mix of clocks, reads and writes
  task automatic test_note_sequences(int n_notes);
    logic [7:0] v;
    int         n_clocks;
    int         pick;
    for (int k = 0; k < n_notes; k++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      v = 8'($urandom);
      if ($urandom_range(0, 7) != 0) v[7:6] = 2'b00;
      if ($urandom_range(0, 4) != 0) send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR10_ADDR, v);
      v = 8'($urandom);
      if ($urandom_range(0, 1) != 0) v[5:3] = 3'b111;
      if ($urandom_range(0, 4) != 0) send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR11_ADDR, v);
      v = 8'($urandom);
      if ($urandom_range(0, 5) != 0) v[2] = 1'b0;
      if ($urandom_range(0, 4) != 0) send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR12_ADDR, v);
      v = 8'($urandom);
      if ($urandom_range(0, 5) != 0) v[7:3] = 5'h1F;
      if ($urandom_range(0, 4) != 0) send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR13_ADDR, v);
      v = 8'($urandom);
      v[7] = 1'b1;
      if ($urandom_range(0, 3) != 0) v[2:0] = 3'b111;
      send_item(pcse_pkg::CMD_WRITE, pcse_pkg::NR14_ADDR, v);
      n_clocks = $urandom_range(12, 28);
      repeat (n_clocks) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) send_item(pcse_pkg::CMD_TICK, pick_reg_addr(), 8'($urandom));
        else if (pick < 11) send_item(pcse_pkg::CMD_LENGTH, pick_reg_addr(), 8'($urandom));
        else if (pick < 14) send_item(pcse_pkg::CMD_ENV, pick_reg_addr(), 8'($urandom));
        else if (pick < 17) send_item(pcse_pkg::CMD_SWEEP, pick_reg_addr(), 8'($urandom));
        else if (pick < 19) send_item(pcse_pkg::CMD_READ, pick_reg_addr(), 8'($urandom));
        else send_item(pcse_pkg::CMD_WRITE, pick_reg_addr(), 8'($urandom));
      end
    end
  endtask

  // Hold the result side off while items keep coming, so the input stalls
  task automatic test_input_backpressure();
    gaps_on = 1'b0;
    hold_asked++;
    repeat (40) send_item(3'($urandom_range(pcse_pkg::CMD_READ, pcse_pkg::CMD_SWEEP)),
                          pick_reg_addr(), 8'($urandom));
    gaps_on = 1'b1;
  endtask

  // Any command, any address, any byte
  task automatic test_command_noise(int n_items);
    logic [15:0] addr;
    repeat (n_items) begin
      addr = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                         : pcse_pkg::NR10_ADDR + 16'($urandom_range(0, 5));
      send_item(3'($urandom_range(0, 7)), addr, 8'($urandom));
    end
  endtask

  initial begin
    sw_pace = '0; sw_neg = 1'b0; sw_shift = '0; duty_sel = '0;
    len_left = '0; vol_init = '0; env_up = 1'b0; env_pace = '0;
    period = '0; len_en = 1'b0; enabled = 1'b0; volume = '0;
    env_live = 1'b1; env_cnt = '0; sw_cnt = '0; shadow = '0;
    sw_live = 1'b0; ftimer = '0; step = '0; level = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access_and_corners();
    test_note_sequences(9);
    test_input_backpressure();
    test_command_noise(140);
    test_note_sequences(9);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Receiver: long hold on request, otherwise a stall pattern that changes mode
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (mode_left % 5 != 0);
      endcase
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    chan_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        $error("result with nothing predicted: %h", out_tdata);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("output_level", want.output_level, got.output_level);
        check_field("length_running", want.length_running, got.length_running);
        check_field("channel_on", want.channel_on, got.channel_on);
        check_field("duty_step", want.duty_step, got.duty_step);
        check_field("pad", want.pad, got.pad);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

endmodule

@@ pulse_channel_sweep_envelope_top.f @@
+incdir+src
src/pcse_pkg.sv
src/pcse_front.sv
src/pcse_queue.sv
src/pcse_back.sv
src/pulse_channel_sweep_envelope_top.sv
src/pcse_checker.sv
verif/tb.sv
